@@ hdl/counting_semaphore_table_core_macros.svh @@
// Assertion macros for the semaphore table core.
// Each macro takes a label, the clock, a disable condition, an antecedent,
// a consequent and a message.
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define CST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define CST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/cst_pkg.sv @@
package cst_pkg;

   localparam int CMD_W    = 3;
   localparam int SEM_W    = 9;
   localparam int INIT_W   = 16;
   localparam int STATUS_W = 3;

   localparam int DEFAULT_NUM_SEMAPHORES = 512;
   localparam int DEFAULT_COUNT_WIDTH    = 16;

   // Open flags are kept as rows of this many bits.
   localparam int FLAG_ROW_WIDTH = 32;

   localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_UP    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_DONE         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALREADY_OPEN = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLOSED       = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_WOULD_BLOCK  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL         = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED    = 3'd5;

   typedef struct packed {
      logic capture;
      logic sel_req;
      logic sel_scan;
      logic clear_write;
      logic scan_next;
      logic exec_commit;
      logic alloc_commit;
      logic full_commit;
   } ctrl_type;

   typedef struct packed {
      logic req_is_alloc;
      logic clear_last;
      logic found;
      logic last_row;
      logic out_free;
   } stat_type;

endpackage

@@ hdl/cst_channels.sv @@
interface cst_req_if;
   logic                       valid;
   logic                       ready;
   logic [cst_pkg::CMD_W-1:0]  command;
   logic [cst_pkg::SEM_W-1:0]  sem_index;
   logic [cst_pkg::INIT_W-1:0] init_value;

   modport source(output valid, output command, output sem_index, output init_value,
                  input ready);
   modport sink(input valid, input command, input sem_index, input init_value,
                output ready);
endinterface

interface cst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cst_pkg::STATUS_W-1:0] status;
   logic [cst_pkg::SEM_W-1:0]    sem_out;
   logic                         wake;

   modport source(output valid, output status, output sem_out, output wake,
                  input ready);
   modport sink(input valid, input status, input sem_out, input wake,
                output ready);
endinterface

@@ hdl/cst_controller.sv @@
module cst_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cst_pkg::stat_type stat,
   output cst_pkg::ctrl_type ctrl
);
   import cst_pkg::*;

   typedef enum logic [2:0] {
      CLEARING,
      IDLE,
      EXECUTE,
      SCAN_CHECK,
      SCAN_READ
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEARING;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      ctrl      = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         CLEARING: begin
            ctrl.clear_write = 1'b1;
            if (stat.clear_last) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            req_ready    = 1'b1;
            ctrl.sel_req = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = stat.req_is_alloc ? SCAN_CHECK : EXECUTE;
            end
         end
         EXECUTE: begin
            if (stat.out_free) begin
               ctrl.exec_commit = 1'b1;
               state_in         = IDLE;
            end
         end
         SCAN_CHECK: begin
            ctrl.sel_scan = 1'b1;
            if (stat.found) begin
               if (stat.out_free) begin
                  ctrl.alloc_commit = 1'b1;
                  state_in          = IDLE;
               end
            end else if (stat.last_row) begin
               if (stat.out_free) begin
                  ctrl.full_commit = 1'b1;
                  state_in         = IDLE;
               end
            end else begin
               ctrl.scan_next = 1'b1;
               state_in       = SCAN_READ;
            end
         end
         SCAN_READ: begin
            ctrl.sel_scan = 1'b1;
            state_in      = SCAN_CHECK;
         end
         default: begin
            state_in = CLEARING;
         end
      endcase
   end

endmodule

@@ hdl/cst_datapath.sv @@
module cst_datapath #(
   parameter int NUM_SEMAPHORES = cst_pkg::DEFAULT_NUM_SEMAPHORES,
   parameter int COUNT_WIDTH    = cst_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cst_pkg::ctrl_type            ctrl,
   output cst_pkg::stat_type            stat,
   input  logic [cst_pkg::CMD_W-1:0]    req_command,
   input  logic [cst_pkg::SEM_W-1:0]    req_sem_index,
   input  logic [cst_pkg::INIT_W-1:0]   req_init_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cst_pkg::STATUS_W-1:0] rsp_status,
   output logic [cst_pkg::SEM_W-1:0]    rsp_sem_out,
   output logic                         rsp_wake
);
   import cst_pkg::*;

   localparam int IDX_W = $clog2(NUM_SEMAPHORES);
   localparam int ROWS  = (NUM_SEMAPHORES + FLAG_ROW_WIDTH - 1) / FLAG_ROW_WIDTH;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int BIT_W = $clog2(FLAG_ROW_WIDTH);
   // Number of real entries in the last flag row.
   localparam int TAIL  = NUM_SEMAPHORES - (ROWS - 1) * FLAG_ROW_WIDTH;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [32:0] CNT_MAX_EXT = (33'd1 << COUNT_WIDTH) - 33'd1;

   logic [FLAG_ROW_WIDTH-1:0] flag_mem [ROWS];
   logic [COUNT_WIDTH-1:0]    count_mem [NUM_SEMAPHORES];

   logic [CMD_W-1:0]          cmd_ff;
   logic [SEM_W-1:0]          idx_ff;
   logic [INIT_W-1:0]         init_ff;
   logic [ROW_W-1:0]          scan_row_ff;
   logic [ROW_W-1:0]          clear_row_ff;
   logic [FLAG_ROW_WIDTH-1:0] flag_row_ff;
   logic [COUNT_WIDTH-1:0]    count_rd_ff;
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [SEM_W-1:0]          rsp_sem_ff;
   logic                      rsp_wake_ff;

   logic [ROW_W-1:0]          flag_ra;
   logic [IDX_W-1:0]          count_ra;
   logic                      flag_we;
   logic [ROW_W-1:0]          flag_wa;
   logic [FLAG_ROW_WIDTH-1:0] flag_wd;
   logic                      count_we;
   logic [IDX_W-1:0]          count_wa;
   logic [COUNT_WIDTH-1:0]    count_wd;

   logic [FLAG_ROW_WIDTH-1:0] free_vec;
   logic                      found;
   logic [BIT_W-1:0]          found_bit;
   logic [ROW_W+BIT_W-1:0]    found_idx;
   logic [FLAG_ROW_WIDTH-1:0] alloc_row_wd;

   logic [ROW_W-1:0]          idx_row;
   logic [BIT_W-1:0]          idx_bit;
   logic                      in_range;
   logic                      is_open;
   logic                      init_big;
   logic [COUNT_WIDTH-1:0]    start_val;
   logic [STATUS_W-1:0]       start_status;

   logic [STATUS_W-1:0]       ex_status;
   logic                      ex_wake;
   logic                      ex_flag_we;
   logic                      ex_flag_val;
   logic                      ex_count_we;
   logic [COUNT_WIDTH-1:0]    ex_count_val;
   logic [FLAG_ROW_WIDTH-1:0] ex_row_wd;
   logic                      any_commit;

   // Read addresses: the incoming word in idle, else the held request or the scan row.
   always_comb begin
      if (ctrl.sel_req) begin
         flag_ra  = (req_command == CMD_ALLOC) ? '0
                    : ROW_W'(32'(req_sem_index) / FLAG_ROW_WIDTH);
         count_ra = IDX_W'(req_sem_index);
      end else begin
         flag_ra  = ctrl.sel_scan ? scan_row_ff : idx_row;
         count_ra = IDX_W'(idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_wa] <= flag_wd;
      end
      flag_row_ff <= flag_mem[flag_ra];
   end

   always_ff @(posedge clock) begin
      if (count_we) begin
         count_mem[count_wa] <= count_wd;
      end
      count_rd_ff <= count_mem[count_ra];
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff  <= req_command;
         idx_ff  <= req_sem_index;
         init_ff <= req_init_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_row_ff  <= '0;
         clear_row_ff <= '0;
      end else begin
         if (ctrl.capture) begin
            scan_row_ff <= '0;
         end else if (ctrl.scan_next) begin
            scan_row_ff <= scan_row_ff + ROW_W'(1);
         end
         if (ctrl.clear_write) begin
            clear_row_ff <= clear_row_ff + ROW_W'(1);
         end
      end
   end

   // Lowest closed entry of the row under scan; padding bits of the last row count as open.
   always_comb begin
      free_vec = ~flag_row_ff;
      if (scan_row_ff == LAST_ROW) begin
         for (int b = 0; b < FLAG_ROW_WIDTH; b++) begin
            if (b >= TAIL) begin
               free_vec[b] = 1'b0;
            end
         end
      end
      found     = 1'b0;
      found_bit = '0;
      for (int b = FLAG_ROW_WIDTH - 1; b >= 0; b--) begin
         if (free_vec[b]) begin
            found     = 1'b1;
            found_bit = BIT_W'(b);
         end
      end
      found_idx             = {scan_row_ff, found_bit};
      alloc_row_wd          = flag_row_ff;
      alloc_row_wd[found_bit] = 1'b1;
   end

   always_comb begin
      idx_row      = ROW_W'(32'(idx_ff) / FLAG_ROW_WIDTH);
      idx_bit      = BIT_W'(32'(idx_ff) % FLAG_ROW_WIDTH);
      in_range     = 32'(idx_ff) < 32'(NUM_SEMAPHORES);
      is_open      = in_range && flag_row_ff[idx_bit];
      init_big     = 33'(init_ff) > CNT_MAX_EXT;
      start_val    = init_big ? '1 : COUNT_WIDTH'(init_ff);
      start_status = init_big ? STATUS_SATURATED : STATUS_DONE;
   end

   always_comb begin
      ex_status    = STATUS_DONE;
      ex_wake      = 1'b0;
      ex_flag_we   = 1'b0;
      ex_flag_val  = 1'b0;
      ex_count_we  = 1'b0;
      ex_count_val = start_val;
      case (cmd_ff)
         CMD_OPEN: begin
            if (!in_range) begin
               ex_status = STATUS_CLOSED;
            end else if (is_open) begin
               ex_status = STATUS_ALREADY_OPEN;
            end else begin
               ex_status   = start_status;
               ex_flag_we  = 1'b1;
               ex_flag_val = 1'b1;
               ex_count_we = 1'b1;
            end
         end
         CMD_CLOSE: begin
            if (!is_open) begin
               ex_status = STATUS_CLOSED;
            end else begin
               ex_flag_we = 1'b1;
            end
         end
         CMD_UP: begin
            if (!is_open) begin
               ex_status = STATUS_CLOSED;
            end else if (count_rd_ff == {COUNT_WIDTH{1'b1}}) begin
               ex_status = STATUS_SATURATED;
            end else begin
               ex_wake      = (count_rd_ff == '0);
               ex_count_we  = 1'b1;
               ex_count_val = count_rd_ff + COUNT_WIDTH'(1);
            end
         end
         CMD_DOWN: begin
            if (!is_open) begin
               ex_status = STATUS_CLOSED;
            end else if (count_rd_ff == '0) begin
               ex_status = STATUS_WOULD_BLOCK;
            end else begin
               ex_count_we  = 1'b1;
               ex_count_val = count_rd_ff - COUNT_WIDTH'(1);
            end
         end
         default: begin
            ex_status = STATUS_DONE;
         end
      endcase
      ex_row_wd          = flag_row_ff;
      ex_row_wd[idx_bit] = ex_flag_val;
   end

   always_comb begin
      flag_we  = ctrl.clear_write || ctrl.alloc_commit || (ctrl.exec_commit && ex_flag_we);
      count_we = ctrl.alloc_commit || (ctrl.exec_commit && ex_count_we);
      if (ctrl.clear_write) begin
         flag_wa = clear_row_ff;
         flag_wd = '0;
      end else if (ctrl.alloc_commit) begin
         flag_wa = scan_row_ff;
         flag_wd = alloc_row_wd;
      end else begin
         flag_wa = idx_row;
         flag_wd = ex_row_wd;
      end
      if (ctrl.alloc_commit) begin
         count_wa = IDX_W'(found_idx);
         count_wd = start_val;
      end else begin
         count_wa = IDX_W'(idx_ff);
         count_wd = ex_count_val;
      end
   end

   assign any_commit = ctrl.exec_commit || ctrl.alloc_commit || ctrl.full_commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (any_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec_commit) begin
         rsp_status_ff <= ex_status;
         rsp_sem_ff    <= idx_ff;
         rsp_wake_ff   <= ex_wake;
      end else if (ctrl.alloc_commit) begin
         rsp_status_ff <= start_status;
         rsp_sem_ff    <= SEM_W'(found_idx);
         rsp_wake_ff   <= 1'b0;
      end else if (ctrl.full_commit) begin
         rsp_status_ff <= STATUS_FULL;
         rsp_sem_ff    <= '0;
         rsp_wake_ff   <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_sem_out = rsp_sem_ff;
   assign rsp_wake    = rsp_wake_ff;

   assign stat.req_is_alloc = (req_command == CMD_ALLOC);
   assign stat.clear_last   = (clear_row_ff == LAST_ROW);
   assign stat.found        = found;
   assign stat.last_row     = (scan_row_ff == LAST_ROW);
   assign stat.out_free     = !rsp_valid_ff || rsp_ready;

endmodule

@@ hdl/counting_semaphore_table_core.sv @@
// Table of counting semaphores, every entry closed after reset.
// The request channel carries one command word (open, allocate, close, up,
// down) with an entry index and an initial count; the response channel
// returns exactly one word per command: status, entry index and wake flag.
// Open flags live in a memory of 32-bit rows, counts in a memory of one word
// per entry; each command is a read-modify-write through these memories.
// Open, close, up and down register the memory reads after the accept, then
// update the table and load the response before the next accept.
// Allocate scans the flag rows in order, reading each row and then
// checking it, until it finds a free entry or has checked the last row,
// which answers that the table is full.
// After reset a clearing pass writes every flag row to closed, one row per
// cycle (rows = ceil(NUM_SEMAPHORES/32), 16 by default); requests are held
// off until it ends. Counts need no clearing.
// The response sits in an output register. A new request is taken while an
// earlier response still waits; the block only stalls before updating the
// table while that register is full and the receiver holds ready low.
`include "counting_semaphore_table_core_macros.svh"

module counting_semaphore_table_core #(
   parameter int NUM_SEMAPHORES = cst_pkg::DEFAULT_NUM_SEMAPHORES,
   parameter int COUNT_WIDTH    = cst_pkg::DEFAULT_COUNT_WIDTH
) (
   input logic         clock,
   input logic         reset,
   cst_req_if.sink     req_port,
   cst_rsp_if.source   rsp_port
);
   import cst_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   logic     ready;
   logic     any_commit;

   cst_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   cst_datapath #(
      .NUM_SEMAPHORES (NUM_SEMAPHORES),
      .COUNT_WIDTH    (COUNT_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .stat           (stat),
      .req_command    (req_port.command),
      .req_sem_index  (req_port.sem_index),
      .req_init_value (req_port.init_value),
      .rsp_valid      (rsp_port.valid),
      .rsp_ready      (rsp_port.ready),
      .rsp_status     (rsp_port.status),
      .rsp_sem_out    (rsp_port.sem_out),
      .rsp_wake       (rsp_port.wake)
   );

   assign req_port.ready = ready;
   assign any_commit     = ctrl.exec_commit || ctrl.alloc_commit || ctrl.full_commit;

   // The clearing pass must follow reset before any request is taken.
   `CST_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_port.ready, "request taken during clearing pass")
   // The table is only updated when the response register can take the word.
   `CST_ASSERT_NOW(a_commit_needs_slot, clock, reset, any_commit, stat.out_free, "table updated while response register is blocked")
   // One command at a time: an accepted word holds off the next.
   `CST_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_port.valid && req_port.ready, !req_port.ready, "request taken while a command is in flight")
   // A response only appears after a command finished.
   `CST_ASSERT_NOW(a_rsp_from_commit, clock, reset, $rose(rsp_port.valid), $past(any_commit), "response raised without a finished command")

endmodule

@@ test/semaphore_table_checker.sv @@
`timescale 1ns / 1ps

module semaphore_table_checker (
   input  logic clock,
   input  logic reset,
   cst_req_if   req_mon,
   cst_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   import cst_pkg::*;

   localparam int NUM_ENTRIES = DEFAULT_NUM_SEMAPHORES;
   localparam int COUNT_W     = DEFAULT_COUNT_WIDTH;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SEM_W-1:0]    sem_out;
      logic                wake;
   } reply_t;

   bit                 entry_open [NUM_ENTRIES];
   logic [COUNT_W-1:0] entry_count [NUM_ENTRIES];
   reply_t             awaited_replies [$];

   function automatic logic [COUNT_W-1:0] starting_count(input logic [INIT_W-1:0] init,
                                                         output logic [STATUS_W-1:0] status);
      if (init > COUNT_MAX) begin
         status = STATUS_SATURATED;
         return COUNT_MAX;
      end
      status = STATUS_DONE;
      return COUNT_W'(init);
   endfunction

   // Applies one command word to the table copy and returns the reply it earns.
   function automatic reply_t semaphore_outcome(input logic [CMD_W-1:0]  cmd,
                                                input logic [SEM_W-1:0]  idx,
                                                input logic [INIT_W-1:0] init);
      reply_t r;
      logic   found;
      logic   in_range;
      r.status = STATUS_DONE;
      r.sem_out = idx;
      r.wake = 1'b0;
      found = 1'b0;
      in_range = int'(idx) < NUM_ENTRIES;
      case (cmd)
         CMD_ALLOC: begin
            r.sem_out = '0;
            r.status = STATUS_FULL;
            for (int k = 0; k < NUM_ENTRIES; k++) begin
               if (!found && !entry_open[k]) begin
                  found = 1'b1;
                  entry_open[k] = 1'b1;
                  entry_count[k] = starting_count(init, r.status);
                  r.sem_out = SEM_W'(k);
               end
            end
         end
         CMD_OPEN: begin
            if (!in_range) begin
               r.status = STATUS_CLOSED;
            end else if (entry_open[idx]) begin
               r.status = STATUS_ALREADY_OPEN;
            end else begin
               entry_open[idx] = 1'b1;
               entry_count[idx] = starting_count(init, r.status);
            end
         end
         CMD_CLOSE, CMD_UP, CMD_DOWN: begin
            if (!in_range || !entry_open[idx]) begin
               r.status = STATUS_CLOSED;
            end else if (cmd == CMD_CLOSE) begin
               entry_open[idx] = 1'b0;
            end else if (cmd == CMD_UP) begin
               if (entry_count[idx] == COUNT_MAX) begin
                  r.status = STATUS_SATURATED;
               end else begin
                  r.wake = (entry_count[idx] == '0);
                  entry_count[idx] = entry_count[idx] + COUNT_W'(1);
               end
            end else begin
               if (entry_count[idx] == '0) r.status = STATUS_WOULD_BLOCK;
               else entry_count[idx] = entry_count[idx] - COUNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch_channels
      reply_t want;
      reply_t got;
      if (reset) begin
         foreach (entry_open[k]) entry_open[k] = 1'b0;
         awaited_replies.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status = rsp_mon.status;
            got.sem_out = rsp_mon.sem_out;
            got.wake = rsp_mon.wake;
            if (awaited_replies.size() == 0) begin
               $display("%0t: unexpected reply word status %0d sem_out %0d wake %0b",
                        $time, got.status, got.sem_out, got.wake);
               fail_count++;
            end else begin
               want = awaited_replies.pop_front();
               if (got.status !== want.status || got.sem_out !== want.sem_out ||
                   got.wake !== want.wake) begin
                  $display("%0t: expected status %0d sem_out %0d wake %0b, %s %0d %0d %0b",
                           $time, want.status, want.sem_out, want.wake,
                           "got", got.status, got.sem_out, got.wake);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            awaited_replies.push_back(semaphore_outcome(req_mon.command, req_mon.sem_index,
                                                        req_mon.init_value));
      end
      pending = awaited_replies.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import cst_pkg::*;

   // Command codes past CMD_DOWN have no meaning and must be answered as done.
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;
   localparam int NUM_ENTRIES  = DEFAULT_NUM_SEMAPHORES;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 64;
   localparam logic [INIT_W-1:0] INIT_MAX   = '1;
   localparam logic [SEM_W-1:0]  LAST_ENTRY = SEM_W'(NUM_ENTRIES - 1);
   localparam logic [SEM_W-1:0]  PLAIN_ENTRY = 9'd5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm = 1'b0;
   int   fail_count;
   int   pending;
   int   idle_cycles = 0;

   cst_req_if req_ch();
   cst_rsp_if rsp_ch();

   counting_semaphore_table_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   semaphore_table_checker monitor (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("counting_semaphore_table_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Mostly short pauses, now and then a long one; none at all while calm.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [INIT_W-1:0] random_init();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return INIT_W'($urandom_range(0, 2));
      if (roll < 55) return INIT_MAX - INIT_W'($urandom_range(0, 2));
      return INIT_W'($urandom_range(0, INIT_MAX));
   endfunction

   // Most traffic hits a small set of entries so that commands interact.
   function automatic logic [SEM_W-1:0] random_index();
      if ($urandom_range(0, 99) < 80) return SEM_W'($urandom_range(0, 15));
      return SEM_W'($urandom_range(0, NUM_ENTRIES - 1));
   endfunction

   // Called and returns at a falling edge; valid stays high between
   // back-to-back words.
   task automatic send_word(input logic [CMD_W-1:0]  cmd,
                            input logic [SEM_W-1:0]  idx,
                            input logic [INIT_W-1:0] init);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.command = cmd;
      req_ch.sem_index = idx;
      req_ch.init_value = init;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic mixed_traffic(input int total);
      int sent;
      int len;
      int roll;
      logic [SEM_W-1:0]  idx;
      logic [CMD_W-1:0]  cmd;
      sent = 0;
      while (sent < total) begin
         if ($urandom_range(0, 29) == 0) calm = !calm;
         idx = random_index();
         if ($urandom_range(0, 1) != 0) begin
            // A short life of one entry: open, a run of ups and downs, maybe close.
            len = $urandom_range(2, 10);
            send_word(CMD_OPEN, idx, random_init());
            repeat (len)
               send_word(($urandom_range(0, 1) != 0) ? CMD_UP : CMD_DOWN, idx, random_init());
            if ($urandom_range(0, 2) != 0) send_word(CMD_CLOSE, idx, random_init());
            sent += len + 2;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 15) cmd = CMD_OPEN;
            else if (roll < 30) cmd = CMD_ALLOC;
            else if (roll < 45) cmd = CMD_CLOSE;
            else if (roll < 70) cmd = CMD_UP;
            else if (roll < 95) cmd = CMD_DOWN;
            else cmd = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
            send_word(cmd, idx, random_init());
            sent++;
         end
      end
      calm = 1'b0;
   endtask

   initial begin : receiver
      int hold;
      rsp_ch.ready = 1'b0;
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
   end

   initial begin : stimulus
      req_ch.valid = 1'b0;
      req_ch.command = CMD_OPEN;
      req_ch.sem_index = '0;
      req_ch.init_value = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Commands on a closed entry.
      send_word(CMD_UP, PLAIN_ENTRY, '0);
      send_word(CMD_DOWN, PLAIN_ENTRY, '0);
      send_word(CMD_CLOSE, PLAIN_ENTRY, '0);
      // Open, reopen, blocking down, wake on the way up from zero.
      send_word(CMD_OPEN, PLAIN_ENTRY, '0);
      send_word(CMD_OPEN, PLAIN_ENTRY, 16'd7);
      send_word(CMD_DOWN, PLAIN_ENTRY, '0);
      send_word(CMD_UP, PLAIN_ENTRY, '0);
      send_word(CMD_UP, PLAIN_ENTRY, '0);
      send_word(CMD_DOWN, PLAIN_ENTRY, '0);
      send_word(CMD_DOWN, PLAIN_ENTRY, '0);
      send_word(CMD_DOWN, PLAIN_ENTRY, '0);
      // Counter at its ceiling on the last entry.
      send_word(CMD_OPEN, LAST_ENTRY, INIT_MAX);
      send_word(CMD_UP, LAST_ENTRY, '0);
      send_word(CMD_DOWN, LAST_ENTRY, '0);
      send_word(CMD_UP, LAST_ENTRY, '0);
      send_word(CMD_UP, LAST_ENTRY, '0);
      // Allocation takes the lowest closed entry, and reuses a freed one.
      send_word(CMD_ALLOC, LAST_ENTRY, 16'h8000);
      send_word(CMD_ALLOC, '0, 16'd1);
      send_word(CMD_CLOSE, '0, '0);
      send_word(CMD_ALLOC, '0, INIT_MAX);
      for (int c = int'(CMD_UNKNOWN_LO); c <= int'(CMD_UNKNOWN_HI); c++)
         send_word(CMD_W'(c), LAST_ENTRY, INIT_MAX);
      send_word(CMD_CLOSE, PLAIN_ENTRY, '0);
      send_word(CMD_CLOSE, LAST_ENTRY, '0);
      send_word(CMD_UP, LAST_ENTRY, '0);

      mixed_traffic(400);

      // Fill the whole table and keep allocating into a full one.
      repeat (530) send_word(CMD_ALLOC, SEM_W'($urandom), random_init());
      repeat (30) begin
         send_word(CMD_CLOSE, SEM_W'($urandom_range(0, NUM_ENTRIES - 1)), random_init());
         send_word(CMD_ALLOC, SEM_W'($urandom), random_init());
         if ($urandom_range(0, 2) == 0) send_word(CMD_ALLOC, SEM_W'($urandom), random_init());
      end
      for (int k = 0; k < 64; k++) send_word(CMD_CLOSE, SEM_W'(k), random_init());

      mixed_traffic(420);

      req_ch.valid = 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("counting_semaphore_table_core: match");
      else
         $display("counting_semaphore_table_core: mismatch");
      $finish;
   end

endmodule
